@@ rtl/particle_attractor_update_core_macros.svh @@
// assertion helpers for the particle update core
`ifndef PARTICLE_ATTRACTOR_UPDATE_CORE_MACROS_SVH
`define PARTICLE_ATTRACTOR_UPDATE_CORE_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define PAU_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pau_pkg.sv @@
package pau_pkg;

  // table size and field widths
  localparam int PARTICLES  = 16384;
  localparam int IDX_W      = 14;
  localparam int ADDR_W     = $clog2(PARTICLES);
  localparam int POS_W      = 32;
  localparam int VEL_W      = 24;
  localparam int MOUSE_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int COL_W      = 8;

  // configuration widths
  localparam int GAIN_W     = 16;
  localparam int DAMP_W     = 16;
  localparam int SCALE_W    = 4;
  localparam int CSCALE_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int DIST_W     = POS_W + 2;
  localparam int MAG_W      = POS_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = 2 * POS_W;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int NUM_W      = MAG_W + GAIN_W;
  localparam int Q_W        = GAIN_W;
  localparam int F_W        = Q_W + 1;
  localparam int T_W        = VEL_W + 1 + CSCALE_W;
  localparam int DM_W       = VEL_W + DAMP_W;
  localparam int SC_W       = VEL_W + SCALE_W + 1;

  // far-distance shift and its rounding for negative values
  localparam int SHIFT_S    = 3;
  localparam int SHIFT_RND  = (1 << SHIFT_S) - 1;

  // colour bands
  localparam int RED_MAX    = 255;
  localparam int GB_SAT     = 63;
  localparam int BAND_MID   = 128;
  localparam int GB_BASE    = 158;

  // pipeline stage positions
  localparam int ST_SQ0      = 5;
  localparam int ST_SQ_LAST  = ST_SQ0 + ROOT_W - 1;
  localparam int ST_DV0      = ST_SQ_LAST + 1;
  localparam int ST_DV_LAST  = ST_DV0 + Q_W - 1;
  localparam int ST_VEL      = ST_DV_LAST + 1;
  localparam int ST_COL      = ST_VEL + 1;
  localparam int ST_LAST     = ST_COL + 1;
  localparam int NSTG        = ST_LAST + 1;

  // register reset values
  localparam logic [GAIN_W-1:0]   FORCE_GAIN_RST  = 16'd13107;
  localparam logic [DAMP_W-1:0]   DAMPING_RST     = 16'd64881;
  localparam logic [SCALE_W-1:0]  STEP_SCALE_RST  = 4'd3;
  localparam logic [CSCALE_W-1:0] COLOR_SCALE_RST = 8'd30;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_GAIN  = 3'd0,
    CFG_DAMPING     = 3'd1,
    CFG_STEP_SCALE  = 3'd2,
    CFG_COLOR_SCALE = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    kind_t                      kind;
    logic [IDX_W-1:0]           particle_index;
    logic signed [POS_W-1:0]    load_x;
    logic signed [POS_W-1:0]    load_y;
    logic signed [MOUSE_W-1:0]  mouse_x;
    logic signed [MOUSE_W-1:0]  mouse_y;
    logic                       attract;
    logic                       repel;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [POS_W-1:0]  new_x;
    logic signed [POS_W-1:0]  new_y;
    logic [COL_W-1:0]         red;
    logic [COL_W-1:0]         green;
    logic [COL_W-1:0]         blue;
  } out_item_t;

  // saturate a widened velocity to its stored range
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W+1:0] v);
    if (v[VEL_W+1:VEL_W-1] == {3{v[VEL_W+1]}}) begin
      return v[VEL_W-1:0];
    end
    return v[VEL_W+1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
  endfunction

  // saturate a widened position to its stored range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DIST_W-1:0] p);
    if (p[DIST_W-1:POS_W-1] == {(DIST_W-POS_W+1){p[DIST_W-1]}}) begin
      return p[POS_W-1:0];
    end
    return p[DIST_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

endpackage

@@ rtl/particle_attractor_update_core.sv @@
// Particle update core: a table of 16384 particles (Q16.16 position, Q8.16 velocity) in one
// single-port-read, single-port-write memory. A load beat sets a particle's position and
// clears its velocity; a step beat pulls and/or pushes it along the unit vector from the
// attractor, colours it from its speed, damps the velocity and advances the position, and
// returns one result. The core takes one beat per clock as long as the pipeline is not frozen
// by a stalled result and the particle index of the new beat is not one of the 56 beats
// still in the pipeline; such a beat is held until the earlier one is written back. The
// pipeline spans the read-modify-write around the memory: one read at intake, a 32-stage
// square root and a 16-stage divider, and the write-back at the last stage. A stalled result
// freezes the pipeline only once a result waits behind it; loads and bubbles keep moving.
// Configuration is taken at any time and must be written only while the core is empty.
`include "particle_attractor_update_core_macros.svh"

module particle_attractor_update_core import pau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    kind_t                    step;
    logic                     attract;
    logic                     repel;
    logic                     sx;
    logic                     sy;
    logic                     zero;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
  } ctx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } mem_word_t;

  // configuration registers
  logic [GAIN_W-1:0]   force_gain;
  logic [DAMP_W-1:0]   damping;
  logic [SCALE_W-1:0]  step_scale;
  logic [CSCALE_W-1:0] color_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_gain  <= FORCE_GAIN_RST;
      damping     <= DAMPING_RST;
      step_scale  <= STEP_SCALE_RST;
      color_scale <= COLOR_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FORCE_GAIN:  force_gain  <= cfg_data[GAIN_W-1:0];
        CFG_DAMPING:     damping     <= cfg_data[DAMP_W-1:0];
        CFG_STEP_SCALE:  step_scale  <= cfg_data[SCALE_W-1:0];
        CFG_COLOR_SCALE: color_scale <= cfg_data[CSCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control line
  logic  vld    [NSTG];
  ctx_t  ctx    [NSTG];
  ctx_t  ctx_in [NSTG];
  logic  hit;
  logic  in_range;
  logic  adv;
  logic  accept;
  logic  last_out;

  // particle memory
  mem_word_t          mem [PARTICLES];
  mem_word_t          rd;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_en;
  mem_word_t          wr_data;

  // interlock against any in-flight beat on the same particle
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NSTG; i++) begin
      if (vld[i] && ctx[i].idx == item.particle_index) begin
        hit = 1'b1;
      end
    end
  end

  assign last_out   = vld[ST_LAST] && (ctx[ST_LAST].step == KIND_STEP);
  assign adv        = !(last_out && result_valid && result_stall);
  assign item_stall = !adv || hit;
  assign accept     = item_valid && !item_stall;
  assign in_range   = (32'(item.particle_index) < PARTICLES);
  assign rd_addr    = item.particle_index[ADDR_W-1:0];
  assign wr_addr    = ctx[ST_LAST].idx[ADDR_W-1:0];
  assign wr_en      = adv && vld[ST_LAST];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // intake stage extras
  logic signed [POS_W-1:0]   load_x0;
  logic signed [POS_W-1:0]   load_y0;
  logic signed [MOUSE_W-1:0] mouse_x0;
  logic signed [MOUSE_W-1:0] mouse_y0;

  always_ff @(posedge clk) begin
    if (adv) begin
      load_x0  <= item.load_x;
      load_y0  <= item.load_y;
      mouse_x0 <= item.mouse_x;
      mouse_y0 <= item.mouse_y;
    end
  end

  // distance from the attractor
  logic signed [POS_W-1:0]  px_s0;
  logic signed [POS_W-1:0]  py_s0;
  logic signed [DIST_W-1:0] mx_ext;
  logic signed [DIST_W-1:0] my_ext;
  logic signed [DIST_W-1:0] dx1;
  logic signed [DIST_W-1:0] dy1;

  assign px_s0  = (ctx[0].step == KIND_STEP) ? rd.px : load_x0;
  assign py_s0  = (ctx[0].step == KIND_STEP) ? rd.py : load_y0;
  assign mx_ext = {{(DIST_W-MOUSE_W-FRAC_W){mouse_x0[MOUSE_W-1]}}, mouse_x0, {FRAC_W{1'b0}}};
  assign my_ext = {{(DIST_W-MOUSE_W-FRAC_W){mouse_y0[MOUSE_W-1]}}, mouse_y0, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1 <= DIST_W'(px_s0) - mx_ext;
      dy1 <= DIST_W'(py_s0) - my_ext;
    end
  end

  // magnitudes, scaled down together when either is too large
  logic [DIST_W-1:0] magx1;
  logic [DIST_W-1:0] magy1;
  logic [DIST_W-1:0] rndx1;
  logic [DIST_W-1:0] rndy1;
  logic              big1;
  logic [MAG_W-1:0]  adx2;
  logic [MAG_W-1:0]  ady2;

  assign magx1 = dx1[DIST_W-1] ? DIST_W'(-dx1) : DIST_W'(dx1);
  assign magy1 = dy1[DIST_W-1] ? DIST_W'(-dy1) : DIST_W'(dy1);
  assign big1  = (|magx1[DIST_W-1:MAG_W]) || (|magy1[DIST_W-1:MAG_W]);
  assign rndx1 = dx1[DIST_W-1] ? magx1 + DIST_W'(SHIFT_RND) : magx1;
  assign rndy1 = dy1[DIST_W-1] ? magy1 + DIST_W'(SHIFT_RND) : magy1;

  always_ff @(posedge clk) begin
    if (adv) begin
      adx2 <= big1 ? MAG_W'(rndx1 >> SHIFT_S) : MAG_W'(magx1);
      ady2 <= big1 ? MAG_W'(rndy1 >> SHIFT_S) : MAG_W'(magy1);
    end
  end

  // squares and force numerators
  logic [SQ_W-1:0]  sqx3;
  logic [SQ_W-1:0]  sqy3;
  logic [NUM_W-1:0] numx3;
  logic [NUM_W-1:0] numy3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx3  <= SQ_W'(adx2) * SQ_W'(adx2);
      sqy3  <= SQ_W'(ady2) * SQ_W'(ady2);
      numx3 <= NUM_W'(force_gain) * NUM_W'(adx2);
      numy3 <= NUM_W'(force_gain) * NUM_W'(ady2);
    end
  end

  // squared distance, and numerators riding along the root pipeline
  logic [SUM_W-1:0] sum4;
  logic [NUM_W-1:0] numx_l [ROOT_W+1];
  logic [NUM_W-1:0] numy_l [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sum4      <= SUM_W'(sqx3) + SUM_W'(sqy3);
      numx_l[0] <= numx3;
      numy_l[0] <= numy3;
      for (int j = 1; j <= ROOT_W; j++) begin
        numx_l[j] <= numx_l[j-1];
        numy_l[j] <= numy_l[j-1];
      end
    end
  end

  logic [ROOT_W-1:0] root;
  logic [Q_W-1:0]    qx;
  logic [Q_W-1:0]    qy;

  pau_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (sum4),
    .root     (root)
  );

  pau_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (numx_l[ROOT_W]),
    .den (root),
    .quo (qx)
  );

  pau_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (numy_l[ROOT_W]),
    .den (root),
    .quo (qy)
  );

  // force applied to the velocity
  logic signed [F_W-1:0]   fx;
  logic signed [F_W-1:0]   fy;
  logic signed [VEL_W-1:0] vxa;
  logic signed [VEL_W-1:0] vya;
  logic signed [VEL_W-1:0] vxr;
  logic signed [VEL_W-1:0] vyr;

  assign fx  = ctx[ST_DV_LAST].sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign fy  = ctx[ST_DV_LAST].sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign vxa = ctx[ST_DV_LAST].attract
             ? sat_vel((VEL_W+2)'(ctx[ST_DV_LAST].vx) - (VEL_W+2)'(fx)) : ctx[ST_DV_LAST].vx;
  assign vya = ctx[ST_DV_LAST].attract
             ? sat_vel((VEL_W+2)'(ctx[ST_DV_LAST].vy) - (VEL_W+2)'(fy)) : ctx[ST_DV_LAST].vy;
  assign vxr = ctx[ST_DV_LAST].repel ? sat_vel((VEL_W+2)'(vxa) + (VEL_W+2)'(fx)) : vxa;
  assign vyr = ctx[ST_DV_LAST].repel ? sat_vel((VEL_W+2)'(vya) + (VEL_W+2)'(fy)) : vya;

  // speed for colour and damping products
  logic [VEL_W-1:0] mvx;
  logic [VEL_W-1:0] mvy;
  logic [T_W-1:0]   t_c;
  logic [DM_W-1:0]  dmx_c;
  logic [DM_W-1:0]  dmy_c;

  assign mvx = ctx[ST_VEL].vx[VEL_W-1] ? VEL_W'(-ctx[ST_VEL].vx) : VEL_W'(ctx[ST_VEL].vx);
  assign mvy = ctx[ST_VEL].vy[VEL_W-1] ? VEL_W'(-ctx[ST_VEL].vy) : VEL_W'(ctx[ST_VEL].vy);

  always_ff @(posedge clk) begin
    if (adv) begin
      t_c   <= T_W'((VEL_W+1)'(mvx) + (VEL_W+1)'(mvy)) * T_W'(color_scale);
      dmx_c <= DM_W'(mvx) * DM_W'(damping);
      dmy_c <= DM_W'(mvy) * DM_W'(damping);
    end
  end

  // colour bands, damped velocity and position step
  logic [COL_W-1:0]        red_c;
  logic [COL_W-1:0]        gb_c;
  logic [COL_W-1:0]        r_c;
  logic [COL_W+1:0]        r3_c;
  logic signed [VEL_W-1:0] vdx;
  logic signed [VEL_W-1:0] vdy;
  logic signed [SC_W-1:0]  scx_c;
  logic signed [SC_W-1:0]  scy_c;
  logic [COL_W-1:0]        red_l;
  logic [COL_W-1:0]        gb_l;
  logic signed [SC_W-1:0]  scx_l;
  logic signed [SC_W-1:0]  scy_l;

  assign r_c  = t_c[FRAC_W +: COL_W];
  assign r3_c = (COL_W+2)'({r_c, 1'b0}) + (COL_W+2)'(r_c) + (COL_W+2)'(3);

  always_comb begin
    if (t_c > (T_W'(RED_MAX) << FRAC_W)) begin
      red_c = COL_W'(RED_MAX);
      gb_c  = COL_W'(GB_SAT);
    end else if (t_c >= (T_W'(BAND_MID) << FRAC_W)) begin
      red_c = r_c;
      gb_c  = COL_W'((COL_W+2)'(RED_MAX) - (r3_c >> 2));
    end else begin
      red_c = r_c;
      gb_c  = r_c + COL_W'(GB_BASE);
    end
  end

  assign vdx   = ctx[ST_COL].vx[VEL_W-1] ? -$signed(dmx_c[FRAC_W +: VEL_W])
                                         : $signed(dmx_c[FRAC_W +: VEL_W]);
  assign vdy   = ctx[ST_COL].vy[VEL_W-1] ? -$signed(dmy_c[FRAC_W +: VEL_W])
                                         : $signed(dmy_c[FRAC_W +: VEL_W]);
  assign scx_c = SC_W'(vdx) * SC_W'($signed({1'b0, step_scale}));
  assign scy_c = SC_W'(vdy) * SC_W'($signed({1'b0, step_scale}));

  always_ff @(posedge clk) begin
    if (adv) begin
      red_l <= red_c;
      gb_l  <= gb_c;
      scx_l <= scx_c;
      scy_l <= scy_c;
    end
  end

  // stage inputs along the control line
  always_comb begin
    ctx_in[0]         = '0;
    ctx_in[0].idx     = item.particle_index;
    ctx_in[0].step    = item.kind;
    ctx_in[0].attract = item.attract;
    ctx_in[0].repel   = item.repel;
    for (int i = 1; i < NSTG; i++) begin
      ctx_in[i] = ctx[i-1];
    end
    ctx_in[1].px = px_s0;
    ctx_in[1].py = py_s0;
    ctx_in[1].vx = (ctx[0].step == KIND_STEP) ? rd.vx : '0;
    ctx_in[1].vy = (ctx[0].step == KIND_STEP) ? rd.vy : '0;
    ctx_in[2].sx   = dx1[DIST_W-1];
    ctx_in[2].sy   = dy1[DIST_W-1];
    ctx_in[2].zero = (dx1 == '0) && (dy1 == '0);
    if (!ctx[ST_DV_LAST].zero) begin
      ctx_in[ST_VEL].vx = vxr;
      ctx_in[ST_VEL].vy = vyr;
    end
    ctx_in[ST_LAST].vx = vdx;
    ctx_in[ST_LAST].vy = vdy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= accept && in_range;
      for (int i = 1; i < NSTG; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSTG; i++) begin
        ctx[i] <= ctx_in[i];
      end
    end
  end

  // write-back and result
  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] ny;

  assign nx = sat_pos(DIST_W'(ctx[ST_LAST].px) + DIST_W'(scx_l));
  assign ny = sat_pos(DIST_W'(ctx[ST_LAST].py) + DIST_W'(scy_l));

  always_comb begin
    if (ctx[ST_LAST].step == KIND_STEP) begin
      wr_data = '{px: nx, py: ny, vx: ctx[ST_LAST].vx, vy: ctx[ST_LAST].vy};
    end else begin
      wr_data = '{px: ctx[ST_LAST].px, py: ctx[ST_LAST].py, vx: '0, vy: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (adv && last_out) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_out) begin
      result <= '{out_index: ctx[ST_LAST].idx, new_x: nx, new_y: ny,
                  red: red_l, green: gb_l, blue: gb_l};
    end
  end

  // checks
  `PAU_ASSERT(a_rw_apart, accept && wr_en, rd_addr != wr_addr, "read and write-back hit one entry")
  `PAU_ASSERT(a_zero_root, vld[ST_SQ_LAST], ctx[ST_SQ_LAST].zero == (root == '0), "root disagrees with zero distance")
  `PAU_ASSERT(a_quo_bound, vld[ST_DV_LAST] && !ctx[ST_DV_LAST].zero, qx <= force_gain && qy <= force_gain, "force exceeds gain")
  `PAU_ASSERT_NEXT(a_result_lands, adv && last_out, result_valid, "step left pipeline without result")

endmodule

@@ rtl/pau_isqrt.sv @@
module pau_isqrt import pau_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  typedef struct packed {
    logic [SUM_W-1:0]  bits;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_state_t;

  sq_state_t stage [ROOT_W];

  // one root bit per stage, two radicand bits consumed each time
  for (genvar k = 0; k < ROOT_W; k++) begin : g_iter
    sq_state_t        src;
    logic [REM_W-1:0] part;
    logic [REM_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign src = '{bits: radicand, rem: '0, root: '0};
    end else begin : g_rest
      assign src = stage[k-1];
    end

    assign part  = {src.rem[REM_W-3:0], src.bits[SUM_W-1 -: 2]};
    assign trial = REM_W'({src.root, 2'b01});
    assign take  = (part >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        stage[k].bits <= {src.bits[SUM_W-3:0], 2'b00};
        stage[k].rem  <= take ? part - trial : part;
        stage[k].root <= {src.root[ROOT_W-2:0], take};
      end
    end
  end

  assign root = stage[ROOT_W-1].root;

endmodule

@@ rtl/pau_div.sv @@
module pau_div import pau_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [Q_W-1:0]    quo
);

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [ROOT_W-1:0] den;
    logic [Q_W-1:0]    q;
  } dv_state_t;

  dv_state_t stage [Q_W];

  // restoring division, quotient msb first, one bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_iter
    localparam int B = Q_W - 1 - j;
    dv_state_t        src;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   diff;
    logic             take;

    if (j == 0) begin : g_first
      assign src = '{rem: num, den: den, q: '0};
    end else begin : g_rest
      assign src = stage[j-1];
    end

    assign shifted = (NUM_W+1)'(src.den) << B;
    assign diff    = {1'b0, src.rem} - shifted;
    assign take    = ({1'b0, src.rem} >= shifted);

    always_ff @(posedge clk) begin
      if (en) begin
        stage[j].rem <= take ? diff[NUM_W-1:0] : src.rem;
        stage[j].den <= src.den;
        stage[j].q   <= {src.q[Q_W-2:0], take};
      end
    end
  end

  assign quo = stage[Q_W-1].q;

endmodule
